@@ rtl/core/dnlc_pkg.sv @@
// Shared codes, constants and types of the directory name lookup cache.
package dnlc_pkg;

	// Operation codes carried with the last word of a name.
	localparam logic [2:0] OP_ENTER      = 3'd0;
	localparam logic [2:0] OP_LOOKUP     = 3'd1;
	localparam logic [2:0] OP_REMOVE     = 3'd2;
	localparam logic [2:0] OP_PURGE_DIR  = 3'd3;
	localparam logic [2:0] OP_PURGE_FILE = 3'd4;
	localparam logic [2:0] OP_PURGE_ALL  = 3'd5;

	// Result status codes.
	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_DISABLED = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_STALE    = 3'd4;

	// Name hash multiplier and the width of one stored text word.
	localparam logic [31:0] HASH_MULT = 32'd173;
	localparam int WORD_BITS = 64;

	typedef logic [15:0] handle_t;

	// Command fields latched from the word that ends a name.
	typedef struct packed {
		logic [2:0] op;
		handle_t    dir;
		handle_t    file;
		logic       cur;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [2:0] status;
		handle_t    found;
	} result_t;

endpackage

@@ rtl/core/dnlc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module dnlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered and appears in the cycle after the address; a read of the address
	// being written in the same cycle returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/dnlc_name.sv @@
// Name collector: folds name bytes into the hash and text, then reduces the hash to a bucket.
module dnlc_name #(
	parameter int NAME_LIMIT   = 32,
	parameter int HASH_BUCKETS = 256
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    take,
	input  logic [7:0]                              name_byte,
	input  logic                                    name_last,
	input  logic                                    done,
	output logic                                    idle,
	output logic                                    pend_valid,
	output logic [31:0]                             pend_hash,
	output logic [$clog2(NAME_LIMIT+1)-1:0]         pend_len,
	output logic [((NAME_LIMIT+7)/8)*64-1:0]        pend_text,
	output logic [$clog2(HASH_BUCKETS)-1:0]         pend_bucket
);

	localparam int TEXT_BITS = ((NAME_LIMIT + 7) / 8) * dnlc_pkg::WORD_BITS;
	localparam int LENW = $clog2(NAME_LIMIT + 1);
	localparam int BKW = $clog2(HASH_BUCKETS);
	localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / HASH_BUCKETS;
	localparam logic [31:0] RECIP = RECIP_FULL[31:0];

	typedef enum logic [2:0] {N_COLLECT, N_MUL, N_BACK, N_FIX, N_HOLD} nst_t;

	nst_t                 st_q;
	logic [31:0]          hash_q;
	logic [LENW-1:0]      len_q;
	logic [TEXT_BITS-1:0] text_q;
	logic [63:0]          prod_s1;
	logic [31:0]          qb_s2;
	logic [BKW-1:0]       bucket_q;

	logic [31:0]          hash_d;
	logic [TEXT_BITS-1:0] text_d;
	logic [31:0]          rem;
	logic [31:0]          rem_fix;

	// Next hash and text with the incoming byte placed at the current length.
	always_comb begin
		hash_d = hash_q * dnlc_pkg::HASH_MULT + {24'd0, name_byte};
		text_d = text_q;
		for (int p = 0; p < NAME_LIMIT; p++) begin
			if (len_q == LENW'(p)) begin
				text_d[p*8 +: 8] = name_byte;
			end
		end
	end

	// Remainder after the reciprocal estimate, which is at most one bucket count short.
	always_comb begin
		rem = hash_q - qb_s2;
		rem_fix = (rem >= 32'(HASH_BUCKETS)) ? rem - 32'(HASH_BUCKETS) : rem;
	end

	// Collection and bucket reduction sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_COLLECT;
			hash_q <= '0;
			len_q <= '0;
			text_q <= '0;
			prod_s1 <= '0;
			qb_s2 <= '0;
			bucket_q <= '0;
		end else begin
			case (st_q)
				N_COLLECT: begin
					if (take) begin
						if (name_byte != 8'd0) begin
							hash_q <= hash_d;
							if (len_q < LENW'(NAME_LIMIT)) begin
								text_q <= text_d;
								len_q <= len_q + LENW'(1);
							end
						end
						if (name_last) begin
							st_q <= N_MUL;
						end
					end
				end
				N_MUL: begin
					prod_s1 <= hash_q * RECIP;
					st_q <= N_BACK;
				end
				N_BACK: begin
					qb_s2 <= prod_s1[63:32] * 32'(HASH_BUCKETS);
					st_q <= N_FIX;
				end
				N_FIX: begin
					bucket_q <= rem_fix[BKW-1:0];
					st_q <= N_HOLD;
				end
				N_HOLD: begin
					if (done) begin
						hash_q <= '0;
						len_q <= '0;
						text_q <= '0;
						st_q <= N_COLLECT;
					end
				end
				default: st_q <= N_COLLECT;
			endcase
		end
	end

	assign idle = (st_q == N_COLLECT);
	assign pend_valid = (st_q == N_HOLD);
	assign pend_hash = hash_q;
	assign pend_len = len_q;
	assign pend_text = text_q;
	assign pend_bucket = bucket_q;

endmodule

@@ rtl/core/dnlc_ctrl.sv @@
// Operation sequencer: walks bucket chains, links and unlinks entries, purges and clears.
module dnlc_ctrl #(
	parameter int CACHE_ENTRIES = 256,
	parameter int HASH_BUCKETS  = 256,
	parameter int NAME_LIMIT    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                enable,
	input  logic                                cmd_load,
	input  dnlc_pkg::cmd_t                      cmd,
	input  logic                                pend_valid,
	input  logic [31:0]                         pend_hash,
	input  logic [$clog2(NAME_LIMIT+1)-1:0]     pend_len,
	input  logic [((NAME_LIMIT+7)/8)*64-1:0]    pend_text,
	input  logic [$clog2(HASH_BUCKETS)-1:0]     pend_bucket,
	output logic                                pend_done,
	output logic                                ready,
	output logic                                m_valid,
	input  logic                                m_ready,
	output dnlc_pkg::result_t                   result
);

	localparam int TW = (NAME_LIMIT + 7) / 8;
	localparam int EW = $clog2(CACHE_ENTRIES);
	localparam int BKW = $clog2(HASH_BUCKETS);
	localparam int LENW = $clog2(NAME_LIMIT + 1);
	localparam int SCW = $clog2(CACHE_ENTRIES + 1);
	localparam int TAW = $clog2(CACHE_ENTRIES * TW);
	localparam int CLN = (CACHE_ENTRIES > HASH_BUCKETS) ? CACHE_ENTRIES : HASH_BUCKETS;
	localparam int CLW = $clog2(CLN);
	localparam int JW = $clog2(HASH_BUCKETS + 1);
	localparam int WW = (TW > 1) ? $clog2(TW) : 1;

	typedef struct packed {
		logic [15:0]     dir;
		logic [15:0]     file;
		logic [31:0]     hash;
		logic [LENW-1:0] len;
		logic [BKW-1:0]  bucket;
	} info_t;

	typedef struct packed {
		logic          used;
		logic [EW-1:0] first;
	} bkt_t;

	typedef enum logic [1:0] {U_REMOVE, U_PURGE, U_SCAV} uctx_t;

	typedef enum logic [4:0] {
		C_CLEAR, C_IDLE, C_FB0, C_FB1, C_FE0, C_FE1, C_FT, C_FNEXT, C_HIT, C_NOHIT,
		C_SP1, C_SW0, C_SW1, C_SW2, C_U0, C_U1, C_U2, C_TX, C_I0, C_I1, C_I2, C_I3,
		C_P0, C_P1, C_PN, C_RES
	} cst_t;

	cst_t                st_q;
	uctx_t               uctx_q;
	dnlc_pkg::cmd_t      cmd_q;
	dnlc_pkg::result_t   res_q;
	dnlc_pkg::result_t   out_q;
	logic                out_valid_q;
	logic                clr_op_q;
	logic [CLW-1:0]      clr_q;
	logic [EW-1:0]       ent_q;
	logic [EW-1:0]       head_q;
	logic [EW-1:0]       fw_q;
	logic [EW-1:0]       bw_q;
	logic [EW-1:0]       cnt_q;
	logic [EW-1:0]       idx_q;
	logic [WW-1:0]       wd_q;
	logic [SCW-1:0]      spare_cnt_q;
	logic [BKW-1:0]      sweep_q;
	logic [JW-1:0]       j_q;
	info_t               rec_q;

	// Memory ports.
	logic            info_we;
	logic [EW-1:0]   info_waddr, info_raddr;
	info_t           info_wdata, info_rdata;
	logic            fwd_we;
	logic [EW-1:0]   fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
	logic            bwd_we;
	logic [EW-1:0]   bwd_waddr, bwd_wdata, bwd_raddr, bwd_rdata;
	logic            lnk_we;
	logic [EW-1:0]   lnk_waddr, lnk_raddr;
	logic            lnk_wdata, lnk_rdata;
	logic            bkt_we;
	logic [BKW-1:0]  bkt_waddr, bkt_raddr;
	bkt_t            bkt_wdata, bkt_rdata;
	logic            spr_we;
	logic [EW-1:0]   spr_waddr, spr_wdata, spr_raddr, spr_rdata;
	logic            txt_we;
	logic [TAW-1:0]  txt_waddr, txt_raddr;
	logic [63:0]     txt_wdata, txt_rdata;

	logic [TAW-1:0]  txt_base;
	logic [63:0]     pword;
	logic [SCW-1:0]  spare_top;
	logic            slot_free;
	logic            too_long;
	logic            key_match;
	logic            purge_hit;
	logic            spare_room;
	logic            last_word;
	logic [2:0]      idle_status;

	dnlc_ram #(.WIDTH($bits(info_t)), .DEPTH(CACHE_ENTRIES)) u_info (
		.clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
		.raddr(info_raddr), .rdata(info_rdata)
	);
	dnlc_ram #(.WIDTH(EW), .DEPTH(CACHE_ENTRIES)) u_fwd (
		.clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
		.raddr(fwd_raddr), .rdata(fwd_rdata)
	);
	dnlc_ram #(.WIDTH(EW), .DEPTH(CACHE_ENTRIES)) u_bwd (
		.clk(clk), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
		.raddr(bwd_raddr), .rdata(bwd_rdata)
	);
	dnlc_ram #(.WIDTH(1), .DEPTH(CACHE_ENTRIES)) u_lnk (
		.clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
		.raddr(lnk_raddr), .rdata(lnk_rdata)
	);
	dnlc_ram #(.WIDTH($bits(bkt_t)), .DEPTH(HASH_BUCKETS)) u_bkt (
		.clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
		.raddr(bkt_raddr), .rdata(bkt_rdata)
	);
	dnlc_ram #(.WIDTH(EW), .DEPTH(CACHE_ENTRIES)) u_spare (
		.clk(clk), .we(spr_we), .waddr(spr_waddr), .wdata(spr_wdata),
		.raddr(spr_raddr), .rdata(spr_rdata)
	);
	dnlc_ram #(.WIDTH(dnlc_pkg::WORD_BITS), .DEPTH(CACHE_ENTRIES * TW)) u_text (
		.clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
		.raddr(txt_raddr), .rdata(txt_rdata)
	);

	// Helper terms shared by the sequencer and the memory port logic.
	always_comb begin
		txt_base = TAW'(ent_q) * TAW'(TW);
		pword = pend_text[64*wd_q +: 64];
		spare_top = spare_cnt_q - SCW'(1);
		slot_free = !out_valid_q || m_ready;
		too_long = (pend_len >= LENW'(NAME_LIMIT));
		last_word = (wd_q == WW'(TW - 1));
		key_match = (info_rdata.dir == cmd_q.dir) && (info_rdata.hash == pend_hash) &&
			(info_rdata.len == pend_len);
		purge_hit = lnk_rdata && ((cmd_q.op == dnlc_pkg::OP_PURGE_DIR) ?
			(info_rdata.dir == cmd_q.dir || info_rdata.file == cmd_q.dir) :
			(info_rdata.file == cmd_q.file));
		spare_room = (spare_cnt_q < SCW'(CACHE_ENTRIES));
	end

	// Early status of a new operation: disabled, name too long or stale directory.
	always_comb begin
		if (!enable) begin
			idle_status = dnlc_pkg::ST_DISABLED;
		end else if (too_long && (cmd_q.op == dnlc_pkg::OP_ENTER ||
				cmd_q.op == dnlc_pkg::OP_LOOKUP || cmd_q.op == dnlc_pkg::OP_REMOVE)) begin
			idle_status = dnlc_pkg::ST_TOO_LONG;
		end else if (cmd_q.op == dnlc_pkg::OP_ENTER && !cmd_q.cur) begin
			idle_status = dnlc_pkg::ST_STALE;
		end else begin
			idle_status = dnlc_pkg::ST_DONE;
		end
	end

	// Memory addresses and writes, chosen by the sequencer state.
	always_comb begin
		info_we = 1'b0;
		info_waddr = ent_q;
		info_wdata = rec_q;
		info_raddr = ent_q;
		fwd_we = 1'b0;
		fwd_waddr = ent_q;
		fwd_wdata = ent_q;
		fwd_raddr = ent_q;
		bwd_we = 1'b0;
		bwd_waddr = ent_q;
		bwd_wdata = ent_q;
		bwd_raddr = ent_q;
		lnk_we = 1'b0;
		lnk_waddr = ent_q;
		lnk_wdata = 1'b0;
		lnk_raddr = idx_q;
		bkt_we = 1'b0;
		bkt_waddr = rec_q.bucket;
		bkt_wdata = '0;
		bkt_raddr = pend_bucket;
		spr_we = 1'b0;
		spr_waddr = spare_cnt_q[EW-1:0];
		spr_wdata = ent_q;
		spr_raddr = spare_top[EW-1:0];
		txt_we = 1'b0;
		txt_waddr = txt_base + TAW'(wd_q);
		txt_wdata = pword;
		txt_raddr = txt_base;
		case (st_q)
			C_CLEAR: begin
				lnk_we = ({1'b0, clr_q} < (CLW+1)'(CACHE_ENTRIES));
				lnk_waddr = clr_q[EW-1:0];
				spr_we = lnk_we;
				spr_waddr = clr_q[EW-1:0];
				spr_wdata = clr_q[EW-1:0];
				bkt_we = ({1'b0, clr_q} < (CLW+1)'(HASH_BUCKETS));
				bkt_waddr = clr_q[BKW-1:0];
			end
			C_FT: begin
				txt_raddr = last_word ? txt_base : txt_base + TAW'(wd_q) + TAW'(1);
			end
			C_HIT: begin
				info_we = (cmd_q.op == dnlc_pkg::OP_ENTER);
				info_wdata = '{dir: rec_q.dir, file: cmd_q.file, hash: rec_q.hash,
					len: rec_q.len, bucket: rec_q.bucket};
			end
			C_SW0: begin
				bkt_raddr = sweep_q;
			end
			C_SW1: begin
				bwd_raddr = bkt_rdata.first;
			end
			C_U1: begin
				bkt_raddr = info_rdata.bucket;
			end
			C_U2: begin
				lnk_we = 1'b1;
				if (fw_q == ent_q) begin
					bkt_we = 1'b1;
				end else begin
					bkt_we = (bkt_rdata.first == ent_q);
					bkt_wdata = '{used: 1'b1, first: fw_q};
					fwd_we = 1'b1;
					fwd_waddr = bw_q;
					fwd_wdata = fw_q;
					bwd_we = 1'b1;
					bwd_waddr = fw_q;
					bwd_wdata = bw_q;
				end
				spr_we = (uctx_q != U_SCAV) && spare_room;
			end
			C_TX: begin
				txt_we = 1'b1;
			end
			C_I0: begin
				info_we = 1'b1;
				info_wdata = '{dir: cmd_q.dir, file: cmd_q.file, hash: pend_hash,
					len: pend_len, bucket: pend_bucket};
			end
			C_I1: begin
				bwd_raddr = bkt_rdata.first;
				if (!bkt_rdata.used) begin
					fwd_we = 1'b1;
					bwd_we = 1'b1;
					lnk_we = 1'b1;
					lnk_wdata = 1'b1;
					bkt_we = 1'b1;
					bkt_waddr = pend_bucket;
					bkt_wdata = '{used: 1'b1, first: ent_q};
				end
			end
			C_I2: begin
				fwd_we = 1'b1;
				fwd_wdata = head_q;
				bwd_we = 1'b1;
				bwd_wdata = bwd_rdata;
				lnk_we = 1'b1;
				lnk_wdata = 1'b1;
				bkt_we = 1'b1;
				bkt_waddr = pend_bucket;
				bkt_wdata = '{used: 1'b1, first: ent_q};
			end
			C_I3: begin
				bwd_we = 1'b1;
				bwd_waddr = head_q;
				fwd_we = 1'b1;
				fwd_waddr = bw_q;
			end
			C_P0: begin
				info_raddr = idx_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_CLEAR;
			uctx_q <= U_REMOVE;
			cmd_q <= '0;
			res_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
			clr_op_q <= 1'b0;
			clr_q <= '0;
			ent_q <= '0;
			head_q <= '0;
			fw_q <= '0;
			bw_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			wd_q <= '0;
			spare_cnt_q <= SCW'(CACHE_ENTRIES);
			sweep_q <= '0;
			j_q <= '0;
			rec_q <= '0;
		end else begin
			if (st_q == C_RES && slot_free) begin
				out_valid_q <= 1'b1;
				out_q <= res_q;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_load) begin
				cmd_q <= cmd;
			end
			case (st_q)
				C_CLEAR: begin
					if (clr_q == CLW'(CLN - 1)) begin
						clr_q <= '0;
						spare_cnt_q <= SCW'(CACHE_ENTRIES);
						st_q <= clr_op_q ? C_RES : C_IDLE;
					end else begin
						clr_q <= clr_q + CLW'(1);
					end
				end
				C_IDLE: begin
					res_q <= '{status: idle_status, found: '0};
					if (pend_valid) begin
						if (idle_status != dnlc_pkg::ST_DONE) begin
							st_q <= C_RES;
						end else begin
							case (cmd_q.op)
								dnlc_pkg::OP_ENTER, dnlc_pkg::OP_LOOKUP,
								dnlc_pkg::OP_REMOVE: begin
									st_q <= C_FB0;
								end
								dnlc_pkg::OP_PURGE_DIR, dnlc_pkg::OP_PURGE_FILE: begin
									idx_q <= '0;
									st_q <= C_P0;
								end
								dnlc_pkg::OP_PURGE_ALL: begin
									clr_op_q <= 1'b1;
									clr_q <= '0;
									st_q <= C_CLEAR;
								end
								default: st_q <= C_RES;
							endcase
						end
					end
				end
				C_FB0: st_q <= C_FB1;
				C_FB1: begin
					if (!bkt_rdata.used) begin
						st_q <= C_NOHIT;
					end else begin
						head_q <= bkt_rdata.first;
						ent_q <= bkt_rdata.first;
						cnt_q <= '0;
						st_q <= C_FE0;
					end
				end
				C_FE0: st_q <= C_FE1;
				C_FE1: begin
					rec_q <= info_rdata;
					fw_q <= fwd_rdata;
					wd_q <= '0;
					st_q <= key_match ? C_FT : C_FNEXT;
				end
				C_FT: begin
					if (txt_rdata != pword) begin
						st_q <= C_FNEXT;
					end else if (last_word) begin
						st_q <= C_HIT;
					end else begin
						wd_q <= wd_q + WW'(1);
					end
				end
				C_FNEXT: begin
					if (fw_q == head_q || cnt_q == EW'(CACHE_ENTRIES - 1)) begin
						st_q <= C_NOHIT;
					end else begin
						ent_q <= fw_q;
						cnt_q <= cnt_q + EW'(1);
						st_q <= C_FE0;
					end
				end
				C_HIT: begin
					case (cmd_q.op)
						dnlc_pkg::OP_LOOKUP: begin
							if (rec_q.file == 16'd0) begin
								res_q.status <= dnlc_pkg::ST_MISS;
							end else begin
								res_q.found <= rec_q.file;
							end
							st_q <= C_RES;
						end
						dnlc_pkg::OP_REMOVE: begin
							uctx_q <= U_REMOVE;
							st_q <= C_U0;
						end
						default: st_q <= C_RES;
					endcase
				end
				C_NOHIT: begin
					if (cmd_q.op != dnlc_pkg::OP_ENTER) begin
						res_q.status <= dnlc_pkg::ST_MISS;
						st_q <= C_RES;
					end else if (spare_cnt_q != '0) begin
						st_q <= C_SP1;
					end else begin
						j_q <= '0;
						st_q <= C_SW0;
					end
				end
				C_SP1: begin
					ent_q <= spr_rdata;
					spare_cnt_q <= spare_top;
					wd_q <= '0;
					st_q <= C_TX;
				end
				C_SW0: st_q <= C_SW1;
				C_SW1: begin
					if (bkt_rdata.used) begin
						st_q <= C_SW2;
					end else if (j_q == JW'(HASH_BUCKETS)) begin
						st_q <= C_RES;
					end else begin
						j_q <= j_q + JW'(1);
						sweep_q <= (sweep_q == BKW'(HASH_BUCKETS - 1)) ? '0 : sweep_q + BKW'(1);
						st_q <= C_SW0;
					end
				end
				C_SW2: begin
					ent_q <= bwd_rdata;
					uctx_q <= U_SCAV;
					st_q <= C_U0;
				end
				C_U0: st_q <= C_U1;
				C_U1: begin
					rec_q <= info_rdata;
					fw_q <= fwd_rdata;
					bw_q <= bwd_rdata;
					st_q <= C_U2;
				end
				C_U2: begin
					if (uctx_q != U_SCAV && spare_room) begin
						spare_cnt_q <= spare_cnt_q + SCW'(1);
					end
					wd_q <= '0;
					case (uctx_q)
						U_REMOVE: st_q <= C_RES;
						U_PURGE:  st_q <= C_PN;
						default:  st_q <= C_TX;
					endcase
				end
				C_TX: begin
					if (last_word) begin
						st_q <= C_I0;
					end else begin
						wd_q <= wd_q + WW'(1);
					end
				end
				C_I0: st_q <= C_I1;
				C_I1: begin
					head_q <= bkt_rdata.first;
					st_q <= bkt_rdata.used ? C_I2 : C_RES;
				end
				C_I2: begin
					bw_q <= bwd_rdata;
					st_q <= C_I3;
				end
				C_I3: st_q <= C_RES;
				C_P0: st_q <= C_P1;
				C_P1: begin
					if (purge_hit) begin
						ent_q <= idx_q;
						uctx_q <= U_PURGE;
						st_q <= C_U0;
					end else begin
						st_q <= C_PN;
					end
				end
				C_PN: begin
					if (idx_q == EW'(CACHE_ENTRIES - 1)) begin
						st_q <= C_RES;
					end else begin
						idx_q <= idx_q + EW'(1);
						st_q <= C_P0;
					end
				end
				C_RES: begin
					if (slot_free) begin
						clr_op_q <= 1'b0;
						st_q <= C_IDLE;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	assign pend_done = (st_q == C_RES) && slot_free;
	assign ready = (st_q == C_IDLE);
	assign m_valid = out_valid_q;
	assign result = out_q;

endmodule

@@ rtl/core/directory_name_lookup_cache.sv @@
// Top level of the directory name lookup cache.
// Name bytes stream in one word per cycle while s_tready is high; a word with tlast set
// ends the name and runs the operation in tuser, and only that word yields a result word.
// After the last word the block reduces the hash to a bucket by a reciprocal multiply, a
// multiply back and a correction, then runs the operation against the entry memories,
// which have one read and one write port each, so the time is set by the number of
// memory accesses: a lookup reads each chain entry and compares the text words of those
// whose key matches; an enter also writes (NAME_LIMIT+7)/8 text words and skips empty
// buckets when the oldest entry must be reclaimed; a purge by handle visits every entry
// and frees those that match; purge all runs the clearing pass over max(CACHE_ENTRIES,
// HASH_BUCKETS) addresses. After reset the same clearing pass runs with s_tready low. The
// result sits in an output register; the next name may stream in while it waits.
module directory_name_lookup_cache #(
	parameter int CACHE_ENTRIES = 256,
	parameter int HASH_BUCKETS  = 256,
	parameter int NAME_LIMIT    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,   // cache_enable
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,     // name_byte, dir_handle, file_handle, dir_current
	input  logic        s_tlast,
	input  logic [2:0]  s_tuser,     // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata      // status, found_handle
);

	localparam int LENW = $clog2(NAME_LIMIT + 1);
	localparam int TEXT_BITS = ((NAME_LIMIT + 7) / 8) * dnlc_pkg::WORD_BITS;
	localparam int BKW = $clog2(HASH_BUCKETS);

	logic                 enable_q;
	logic                 take;
	logic                 name_idle;
	logic                 ctrl_ready;
	logic                 pend_valid;
	logic                 pend_done;
	logic [31:0]          pend_hash;
	logic [LENW-1:0]      pend_len;
	logic [TEXT_BITS-1:0] pend_text;
	logic [BKW-1:0]       pend_bucket;
	dnlc_pkg::cmd_t       cmd;
	dnlc_pkg::result_t    result;

	// Enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_wen) begin
			enable_q <= cfg_wdata;
		end
	end

	// Input word handshake and the command carried with it.
	assign s_tready = name_idle && ctrl_ready;
	assign take = s_tvalid && s_tready;
	assign cmd = '{op: s_tuser, dir: s_tdata[23:8], file: s_tdata[39:24], cur: s_tdata[40]};

	dnlc_name #(.NAME_LIMIT(NAME_LIMIT), .HASH_BUCKETS(HASH_BUCKETS)) u_name (
		.clk(clk), .arst_n(arst_n), .take(take), .name_byte(s_tdata[7:0]),
		.name_last(s_tlast), .done(pend_done), .idle(name_idle), .pend_valid(pend_valid),
		.pend_hash(pend_hash), .pend_len(pend_len), .pend_text(pend_text),
		.pend_bucket(pend_bucket)
	);

	dnlc_ctrl #(
		.CACHE_ENTRIES(CACHE_ENTRIES), .HASH_BUCKETS(HASH_BUCKETS), .NAME_LIMIT(NAME_LIMIT)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .enable(enable_q), .cmd_load(take && s_tlast),
		.cmd(cmd), .pend_valid(pend_valid), .pend_hash(pend_hash), .pend_len(pend_len),
		.pend_text(pend_text), .pend_bucket(pend_bucket), .pend_done(pend_done),
		.ready(ctrl_ready), .m_valid(m_tvalid), .m_ready(m_tready), .result(result)
	);

	// Result word packing.
	assign m_tdata = {5'd0, result.found, result.status};

endmodule

@@ rtl/core/dnlc_chk.sv @@
// Port checker for the directory name lookup cache and its bind.
module dnlc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wen,
	input logic        cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic        s_tlast,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Status is always a defined code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= dnlc_pkg::ST_STALE)
		else $error("undefined status code");

	// A handle is returned only with a successful status.
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18:3] != 16'd0 |-> m_tdata[2:0] == dnlc_pkg::ST_DONE)
		else $error("handle returned without success");

	// The word that ends a name blocks input while its operation runs.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken during an operation");

endmodule

bind directory_name_lookup_cache dnlc_chk u_dnlc_chk (.*);
